/* rtl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// No dependencies; imported by ffha_ram users and the top level.
package ffha_pkg;

  localparam int ADDR_W = 12;           // heap offset bits
  localparam int SIZE_W = 13;           // sizes, links, byte counts
  localparam int FA_W   = SIZE_W + 1;   // offset-plus-size sums
  localparam int CNT_W  = 8;            // list length counters

  localparam logic [SIZE_W-1:0] HEAP_SPAN  = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] HEAD_BYTES = SIZE_W'(32);
  localparam logic [SIZE_W-1:0] FOOT_BYTES = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] OVERHEAD   = HEAD_BYTES + FOOT_BYTES;
  localparam logic [SIZE_W-1:0] NO_LINK    = HEAP_SPAN;
  localparam logic [ADDR_W-1:0] LAST_ADDR  = '1;

  localparam logic LIST_AVAIL = 1'b0;
  localparam logic LIST_USED  = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOFIT   = 2'd1,
    STS_IGNORED = 2'd2,
    STS_SMALL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BS_NONE  = 2'd0,
    BS_AVAIL = 2'd1,
    BS_USED  = 2'd2
  } blk_st_t;

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_CLR      = 22'h000002,
    ST_ILAY     = 22'h000004,
    ST_AL_SRCH  = 22'h000008,
    ST_AL_TRIM  = 22'h000010,
    ST_AL_REM   = 22'h000020,
    ST_AL_USE   = 22'h000040,
    ST_FR_CHK   = 22'h000080,
    ST_FR_PUSH  = 22'h000100,
    ST_FR_MARK  = 22'h000200,
    ST_FR_LOW   = 22'h000400,
    ST_FR_LOWCK = 22'h000800,
    ST_MG_RD    = 22'h001000,
    ST_MG_UP    = 22'h002000,
    ST_MG_CHK   = 22'h004000,
    ST_MG_UNL2  = 22'h008000,
    ST_MG_JOIN  = 22'h010000,
    ST_UL_RD    = 22'h020000,
    ST_UL_FIX   = 22'h040000,
    ST_PU_LINK  = 22'h080000,
    ST_PU_FRONT = 22'h100000,
    ST_DONE     = 22'h200000
  } state_t;

  // Footer location of the block at x with payload sz.
  function automatic logic [FA_W-1:0] foot_addr(input logic [ADDR_W-1:0] x,
                                               input logic [SIZE_W-1:0] sz);
    foot_addr = FA_W'(x) + FA_W'(HEAD_BYTES) + FA_W'(sz);
  endfunction

endpackage

/* rtl/ffha_ram.sv */
// Single-write, single-read memory with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int AW = 12,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem [2**AW];

  // write then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

/* rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator: sequencer over five header/link/footer memories.
// Depends on ffha_pkg and ffha_ram.
//
//  channel | ports                                         | direction
//  in      | in_valid in_stall in_op in_request_bytes ...  | item in
//  out     | out_valid out_stall out_status ...            | result out
//  cfg     | cfg_wr_en cfg_wr_data                         | heap_size write
//
// Allocate walks the available list for the first fit; a miss ends after the walk.
// Free merges the block with an available neighbor above and below it; an ignored one changes no list.
// Init clears the block-status memory one entry a cycle.
// Sync active-low reset clears control state; memories are not reset.
// One item at a time; a new item is taken while the last result waits.
module first_fit_heap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [ffha_pkg::SIZE_W-1:0] in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0] in_user_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [ffha_pkg::ADDR_W-1:0] out_block_offset,
  output logic [ffha_pkg::CNT_W-1:0]  out_avail_count,
  output logic [ffha_pkg::SIZE_W-1:0] out_avail_bytes,
  output logic [ffha_pkg::CNT_W-1:0]  out_used_count,
  output logic [ffha_pkg::SIZE_W-1:0] out_used_bytes
);
  import ffha_pkg::*;

  // control state
  state_t              state_r, state_nxt, ret_r, ret_nxt, mret_r, mret_nxt;
  logic [SIZE_W-1:0]   heap_size_r;
  logic [SIZE_W-1:0]   heap_lim_r, heap_lim_nxt;
  logic [SIZE_W-1:0]   avail_front_r, avail_front_nxt, used_front_r, used_front_nxt;
  logic [CNT_W-1:0]    avail_cnt_r, avail_cnt_nxt, used_cnt_r, used_cnt_nxt;
  logic [SIZE_W-1:0]   avail_byt_r, avail_byt_nxt, used_byt_r, used_byt_nxt;
  logic                out_valid_r;

  // working registers
  logic [SIZE_W-1:0]   req_r, req_nxt;
  logic [ADDR_W-1:0]   b_r, b_nxt, nb_r, nb_nxt, low_r, low_nxt, up_r, up_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt, sub_x_r, sub_x_nxt;
  logic [SIZE_W-1:0]   old_r, old_nxt, lsz_r, lsz_nxt, usz_r, usz_nxt;
  logic [SIZE_W-1:0]   sub_sz_r, sub_sz_nxt;
  logic                sub_list_r, sub_list_nxt, nb_ok_r, nb_ok_nxt;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   offset_r, offset_nxt;

  // memory ports
  logic [ADDR_W-1:0]   rd_addr;
  logic                sz_we, st_we, nx_we, pv_we, ft_we;
  logic [ADDR_W-1:0]   sz_wa, st_wa, nx_wa, pv_wa, ft_wa;
  logic [SIZE_W-1:0]   sz_wd, nx_wd, pv_wd, ft_wd;
  logic [1:0]          st_wd;
  logic [SIZE_W-1:0]   sz_rd, nx_rd, pv_rd, ft_rd;
  logic [1:0]          st_rd;

  // datapath temporaries
  logic [SIZE_W-1:0]   front_sel, endv, rem, newsz;
  logic [FA_W-1:0]     fa, sum, bm8;
  logic [ADDR_W-1:0]   bsub;

  ffha_ram #(.AW(ADDR_W), .DW(SIZE_W)) u_size (
    .clk(clk), .we(sz_we), .wa(sz_wa), .wd(sz_wd), .ra(rd_addr), .rd(sz_rd));
  ffha_ram #(.AW(ADDR_W), .DW(2)) u_stat (
    .clk(clk), .we(st_we), .wa(st_wa), .wd(st_wd), .ra(rd_addr), .rd(st_rd));
  ffha_ram #(.AW(ADDR_W), .DW(SIZE_W)) u_next (
    .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd), .ra(rd_addr), .rd(nx_rd));
  ffha_ram #(.AW(ADDR_W), .DW(SIZE_W)) u_prev (
    .clk(clk), .we(pv_we), .wa(pv_wa), .wd(pv_wd), .ra(rd_addr), .rd(pv_rd));
  ffha_ram #(.AW(ADDR_W), .DW(SIZE_W)) u_foot (
    .clk(clk), .we(ft_we), .wa(ft_wa), .wd(ft_wd), .ra(rd_addr), .rd(ft_rd));

  assign in_stall  = (state_r != ST_IDLE);
  assign front_sel = (sub_list_r == LIST_USED) ? used_front_r : avail_front_r;
  assign endv      = (heap_size_r > HEAP_SPAN) ? HEAP_SPAN : heap_size_r;
  assign rem       = old_r - req_r - OVERHEAD;
  assign newsz     = lsz_r + usz_r + OVERHEAD;
  assign bsub      = in_user_offset - ADDR_W'(HEAD_BYTES);
  assign bm8       = FA_W'(b_r) - FA_W'(FOOT_BYTES);

  // sequencer
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  mret_nxt = mret_r;
    heap_lim_nxt = heap_lim_r;
    avail_front_nxt = avail_front_r;  used_front_nxt = used_front_r;
    avail_cnt_nxt = avail_cnt_r;  used_cnt_nxt = used_cnt_r;
    avail_byt_nxt = avail_byt_r;  used_byt_nxt = used_byt_r;
    req_nxt = req_r;  b_nxt = b_r;  nb_nxt = nb_r;  low_nxt = low_r;  up_nxt = up_r;
    clr_nxt = clr_r;  sub_x_nxt = sub_x_r;  sub_sz_nxt = sub_sz_r;
    sub_list_nxt = sub_list_r;  nb_ok_nxt = nb_ok_r;
    old_nxt = old_r;  lsz_nxt = lsz_r;  usz_nxt = usz_r;
    status_nxt = status_r;  offset_nxt = offset_r;
    rd_addr = sub_x_r;
    sz_we = 1'b0;  sz_wa = b_r;  sz_wd = req_r;
    st_we = 1'b0;  st_wa = b_r;  st_wd = 2'(BS_NONE);
    nx_we = 1'b0;  nx_wa = sub_x_r;  nx_wd = front_sel;
    pv_we = 1'b0;  pv_wa = sub_x_r;  pv_wd = NO_LINK;
    ft_we = 1'b0;  ft_wa = '0;  ft_wd = req_r;
    fa = '0;  sum = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STS_OK;
          offset_nxt = '0;
          req_nxt    = in_request_bytes;
          unique case (op_t'(in_op))
            OP_ALLOC: begin
              if (avail_front_r >= heap_lim_r) begin
                status_nxt = STS_NOFIT;
                state_nxt  = ST_DONE;
              end else begin
                rd_addr   = avail_front_r[ADDR_W-1:0];
                b_nxt     = avail_front_r[ADDR_W-1:0];
                state_nxt = ST_AL_SRCH;
              end
            end
            OP_FREE: begin
              if (in_user_offset < ADDR_W'(HEAD_BYTES) ||
                  {1'b0, bsub} >= heap_lim_r) begin
                status_nxt = STS_IGNORED;
                state_nxt  = ST_DONE;
              end else begin
                rd_addr   = bsub;
                b_nxt     = bsub;
                state_nxt = ST_FR_CHK;
              end
            end
            OP_INIT: begin
              avail_front_nxt = NO_LINK;  used_front_nxt = NO_LINK;
              avail_cnt_nxt = '0;  used_cnt_nxt = '0;
              avail_byt_nxt = '0;  used_byt_nxt = '0;
              heap_lim_nxt = '0;
              clr_nxt = '0;
              state_nxt = ST_CLR;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // sweep the block-status memory
      ST_CLR: begin
        st_we = 1'b1;  st_wa = clr_r;  st_wd = 2'(BS_NONE);
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) state_nxt = ST_ILAY;
      end

      // lay out one available block over the heap
      ST_ILAY: begin
        if (endv < OVERHEAD) begin
          status_nxt = STS_SMALL;
          state_nxt  = ST_DONE;
        end else begin
          heap_lim_nxt = endv;
          sz_we = 1'b1;  sz_wa = '0;  sz_wd = endv - OVERHEAD;
          st_we = 1'b1;  st_wa = '0;  st_wd = 2'(BS_AVAIL);
          fa = foot_addr('0, endv - OVERHEAD);
          ft_we = (fa < FA_W'(HEAP_SPAN));  ft_wa = fa[ADDR_W-1:0];
          ft_wd = endv - OVERHEAD;
          sub_list_nxt = LIST_AVAIL;  sub_x_nxt = '0;  sub_sz_nxt = endv - OVERHEAD;
          ret_nxt = ST_DONE;  state_nxt = ST_PU_LINK;
        end
      end

      // walk the available list for the first fit
      ST_AL_SRCH: begin
        if ({1'b0, sz_rd} >= FA_W'(req_r) + FA_W'(OVERHEAD)) begin
          sum = FA_W'(b_r) + FA_W'(req_r) + FA_W'(OVERHEAD);
          nb_nxt = sum[ADDR_W-1:0];
          nb_ok_nxt = (sum < FA_W'(HEAP_SPAN));
          old_nxt = sz_rd;
          sub_list_nxt = LIST_AVAIL;  sub_x_nxt = b_r;  sub_sz_nxt = sz_rd;
          ret_nxt = ST_AL_TRIM;  state_nxt = ST_UL_RD;
        end else if (nx_rd >= heap_lim_r) begin
          status_nxt = STS_NOFIT;
          state_nxt  = ST_DONE;
        end else begin
          rd_addr = nx_rd[ADDR_W-1:0];
          b_nxt   = nx_rd[ADDR_W-1:0];
        end
      end

      ST_AL_TRIM: begin
        sz_we = 1'b1;  sz_wa = b_r;  sz_wd = req_r;
        fa = foot_addr(b_r, req_r);
        ft_we = (fa < FA_W'(HEAP_SPAN));  ft_wa = fa[ADDR_W-1:0];  ft_wd = req_r;
        state_nxt = nb_ok_r ? ST_AL_REM : ST_AL_USE;
      end

      // remainder goes to the front of the available list
      ST_AL_REM: begin
        sz_we = 1'b1;  sz_wa = nb_r;  sz_wd = rem;
        st_we = 1'b1;  st_wa = nb_r;  st_wd = 2'(BS_AVAIL);
        fa = foot_addr(nb_r, rem);
        ft_we = (fa < FA_W'(HEAP_SPAN));  ft_wa = fa[ADDR_W-1:0];  ft_wd = rem;
        sub_list_nxt = LIST_AVAIL;  sub_x_nxt = nb_r;  sub_sz_nxt = rem;
        ret_nxt = ST_AL_USE;  state_nxt = ST_PU_LINK;
      end

      ST_AL_USE: begin
        st_we = 1'b1;  st_wa = b_r;  st_wd = 2'(BS_USED);
        offset_nxt = b_r + ADDR_W'(HEAD_BYTES);
        sub_list_nxt = LIST_USED;  sub_x_nxt = b_r;  sub_sz_nxt = req_r;
        ret_nxt = ST_DONE;  state_nxt = ST_PU_LINK;
      end

      ST_FR_CHK: begin
        if (st_rd != 2'(BS_USED)) begin
          status_nxt = STS_IGNORED;
          state_nxt  = ST_DONE;
        end else begin
          old_nxt = sz_rd;
          sub_list_nxt = LIST_USED;  sub_x_nxt = b_r;  sub_sz_nxt = sz_rd;
          ret_nxt = ST_FR_PUSH;  state_nxt = ST_UL_RD;
        end
      end

      ST_FR_PUSH: begin
        sub_list_nxt = LIST_AVAIL;  sub_x_nxt = b_r;  sub_sz_nxt = old_r;
        ret_nxt = ST_FR_MARK;  state_nxt = ST_PU_LINK;
      end

      ST_FR_MARK: begin
        st_we = 1'b1;  st_wa = b_r;  st_wd = 2'(BS_AVAIL);
        low_nxt = b_r;  mret_nxt = ST_FR_LOW;  state_nxt = ST_MG_RD;
      end

      // find the block below through its footer
      ST_FR_LOW: begin
        if (b_r >= ADDR_W'(FOOT_BYTES)) begin
          rd_addr   = bm8[ADDR_W-1:0];
          state_nxt = ST_FR_LOWCK;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_FR_LOWCK: begin
        if (bm8 >= FA_W'(HEAD_BYTES) + FA_W'(ft_rd)) begin
          sum = bm8 - FA_W'(HEAD_BYTES) - FA_W'(ft_rd);
          low_nxt = sum[ADDR_W-1:0];
          mret_nxt = ST_DONE;  state_nxt = ST_MG_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // merge low_r with the block above when both are available
      ST_MG_RD: begin
        if ({1'b0, low_r} >= heap_lim_r) begin
          state_nxt = mret_r;
        end else begin
          rd_addr = low_r;  state_nxt = ST_MG_UP;
        end
      end

      ST_MG_UP: begin
        sum = FA_W'(low_r) + FA_W'(sz_rd) + FA_W'(OVERHEAD);
        if (st_rd != 2'(BS_AVAIL) || sum >= FA_W'(heap_lim_r)) begin
          state_nxt = mret_r;
        end else begin
          lsz_nxt = sz_rd;  up_nxt = sum[ADDR_W-1:0];
          rd_addr = sum[ADDR_W-1:0];  state_nxt = ST_MG_CHK;
        end
      end

      ST_MG_CHK: begin
        if (st_rd != 2'(BS_AVAIL)) begin
          state_nxt = mret_r;
        end else begin
          usz_nxt = sz_rd;
          sub_list_nxt = LIST_AVAIL;  sub_x_nxt = low_r;  sub_sz_nxt = lsz_r;
          ret_nxt = ST_MG_UNL2;  state_nxt = ST_UL_RD;
        end
      end

      ST_MG_UNL2: begin
        sub_list_nxt = LIST_AVAIL;  sub_x_nxt = up_r;  sub_sz_nxt = usz_r;
        ret_nxt = ST_MG_JOIN;  state_nxt = ST_UL_RD;
      end

      ST_MG_JOIN: begin
        sz_we = 1'b1;  sz_wa = low_r;  sz_wd = newsz;
        st_we = 1'b1;  st_wa = up_r;   st_wd = 2'(BS_NONE);
        fa = foot_addr(low_r, newsz);
        ft_we = (fa < FA_W'(HEAP_SPAN));  ft_wa = fa[ADDR_W-1:0];  ft_wd = newsz;
        sub_list_nxt = LIST_AVAIL;  sub_x_nxt = low_r;  sub_sz_nxt = newsz;
        ret_nxt = mret_r;  state_nxt = ST_PU_LINK;
      end

      // unlink sub_x_r from its list
      ST_UL_RD: begin
        rd_addr = sub_x_r;  state_nxt = ST_UL_FIX;
      end

      ST_UL_FIX: begin
        if (pv_rd < NO_LINK) begin
          nx_we = 1'b1;  nx_wa = pv_rd[ADDR_W-1:0];  nx_wd = nx_rd;
        end else if (sub_list_r == LIST_USED) begin
          used_front_nxt = nx_rd;
        end else begin
          avail_front_nxt = nx_rd;
        end
        pv_we = (nx_rd < NO_LINK);  pv_wa = nx_rd[ADDR_W-1:0];  pv_wd = pv_rd;
        if (sub_list_r == LIST_USED) begin
          used_cnt_nxt = used_cnt_r - CNT_W'(1);
          used_byt_nxt = used_byt_r - (sub_sz_r + OVERHEAD);
        end else begin
          avail_cnt_nxt = avail_cnt_r - CNT_W'(1);
          avail_byt_nxt = avail_byt_r - (sub_sz_r + OVERHEAD);
        end
        state_nxt = ret_r;
      end

      // push sub_x_r on the front of its list
      ST_PU_LINK: begin
        nx_we = 1'b1;  nx_wa = sub_x_r;  nx_wd = front_sel;
        pv_we = 1'b1;  pv_wa = sub_x_r;  pv_wd = NO_LINK;
        state_nxt = ST_PU_FRONT;
      end

      ST_PU_FRONT: begin
        pv_we = (front_sel < NO_LINK);  pv_wa = front_sel[ADDR_W-1:0];
        pv_wd = {1'b0, sub_x_r};
        if (sub_list_r == LIST_USED) begin
          used_front_nxt = {1'b0, sub_x_r};
          used_cnt_nxt = used_cnt_r + CNT_W'(1);
          used_byt_nxt = used_byt_r + sub_sz_r + OVERHEAD;
        end else begin
          avail_front_nxt = {1'b0, sub_x_r};
          avail_cnt_nxt = avail_cnt_r + CNT_W'(1);
          avail_byt_nxt = avail_byt_r + sub_sz_r + OVERHEAD;
        end
        state_nxt = ret_r;
      end

      // hold until the result register is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      heap_size_r   <= HEAP_SPAN;
      heap_lim_r    <= '0;
      avail_front_r <= NO_LINK;
      used_front_r  <= NO_LINK;
      avail_cnt_r   <= '0;
      used_cnt_r    <= '0;
      avail_byt_r   <= '0;
      used_byt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      heap_lim_r    <= heap_lim_nxt;
      avail_front_r <= avail_front_nxt;
      used_front_r  <= used_front_nxt;
      avail_cnt_r   <= avail_cnt_nxt;
      used_cnt_r    <= used_cnt_nxt;
      avail_byt_r   <= avail_byt_nxt;
      used_byt_r    <= used_byt_nxt;
      if (cfg_wr_en) heap_size_r <= cfg_wr_data;
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  mret_r <= mret_nxt;
    req_r <= req_nxt;  b_r <= b_nxt;  nb_r <= nb_nxt;  low_r <= low_nxt;  up_r <= up_nxt;
    clr_r <= clr_nxt;  sub_x_r <= sub_x_nxt;  sub_sz_r <= sub_sz_nxt;
    sub_list_r <= sub_list_nxt;  nb_ok_r <= nb_ok_nxt;
    old_r <= old_nxt;  lsz_r <= lsz_nxt;  usz_r <= usz_nxt;
    status_r <= status_nxt;  offset_r <= offset_nxt;
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_status       <= status_r;
      out_block_offset <= offset_r;
      out_avail_count  <= avail_cnt_r;
      out_avail_bytes  <= avail_byt_r;
      out_used_count   <= used_cnt_r;
      out_used_bytes   <= used_byt_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_heap_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
    heap_lim_r <= HEAP_SPAN)
    else $error("heap end beyond heap");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR && clr_r != LAST_ADDR) |=> state_r == ST_CLR)
    else $error("status clear sweep cut short");

  a_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> ((avail_front_r == NO_LINK) == (avail_cnt_r == '0)))
    else $error("available list front and count disagree");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside completion");
`endif

endmodule
